// ===== rtl/ray_ts_pkg.sv =====
// Shared widths, codes and types of the triangle setup pipeline.
package ray_ts_pkg;

    // Field widths of the stream beats.
    localparam int IDX_IN_W   = 31;
    localparam int IDX_W      = 32;
    localparam int POS_W      = 32;
    localparam int DIST_W     = 48;
    localparam int MAT_W      = 16;

    // Internal arithmetic widths.
    localparam int DIFF_W     = 33;
    localparam int PROD_W     = 66;
    localparam int CROSS_W    = 67;
    localparam int MAG_W      = 66;
    localparam int LEN_W      = 7;
    localparam int M_W        = 31;
    localparam int SQ_W       = 62;
    localparam int SUM_W      = 64;
    localparam int ROOT_W     = 32;
    localparam int ROOT_STEPS = 32;
    localparam int NUM_W      = 62;
    localparam int Q_W        = 31;
    localparam int FRAC_SHIFT = 30;

    // Configuration port.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 31;
    localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_OFFSET = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MATERIAL     = 1'b1;

    // Stream data widths, padded to whole bytes.
    localparam int IN_DATA_W  = 384;
    localparam int OUT_DATA_W = 264;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    typedef logic [2:0][IDX_IN_W-1:0]    idx_in3_t;
    typedef logic [2:0][IDX_W-1:0]       idx3_t;
    typedef logic [2:0][POS_W-1:0]       vec3_t;
    typedef logic [2:0][2:0][POS_W-1:0]  tri_t;   // [vertex][axis]
    typedef logic [2:0][M_W-1:0]         m3_t;
    typedef logic [2:0][Q_W-1:0]         q3_t;

    // Per-triangle facts that ride alongside the normal arithmetic.
    typedef struct packed {
        idx3_t        idx;      // offset indices, already rotated
        axis_t        dropped;
        logic         valid;
        logic         zero;     // cross product is zero
        logic [2:0]   sgn;      // signs of the cross product components
        vec3_t        p0;       // first vertex position
    } side_t;

endpackage

// ===== rtl/ray_ts_front.sv =====
// Edges, cross product, dominant axis, longest edge, normalisation and
// sum of squares. Eight register stages under a common advance enable.
module ray_ts_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic [ray_ts_pkg::IDX_IN_W-1:0]    index_offset,
    input  ray_ts_pkg::idx_in3_t               in_index,
    input  ray_ts_pkg::tri_t                   in_pos,
    output logic                               out_valid,
    output logic [ray_ts_pkg::SUM_W-1:0]       out_sum,
    output ray_ts_pkg::m3_t                    out_m,
    output ray_ts_pkg::side_t                  out_side
);
    localparam int Depth   = 8;
    localparam int DiffW   = ray_ts_pkg::DIFF_W;
    localparam int ProdW   = ray_ts_pkg::PROD_W;
    localparam int CrossW  = ray_ts_pkg::CROSS_W;
    localparam int MagW    = ray_ts_pkg::MAG_W;
    localparam int LenW    = ray_ts_pkg::LEN_W;
    localparam int MW      = ray_ts_pkg::M_W;
    localparam int SqW     = ray_ts_pkg::SQ_W;
    localparam int SumW    = ray_ts_pkg::SUM_W;
    localparam int PosW    = ray_ts_pkg::POS_W;
    localparam int ShiftW  = MagW + MW;

    // Position of the highest set bit plus one, zero for a zero word.
    function automatic logic [LenW-1:0] bit_len(input logic [MagW-1:0] v);
        logic [LenW-1:0] n;
        n = '0;
        for (int i = 0; i < MagW; i++)
        begin
            if (v[i])
            begin
                n = LenW'(i + 1);
            end
        end
        return n;
    endfunction

    logic [Depth-1:0] vld_reg;

    ray_ts_pkg::idx3_t            idx1_reg, idx1_next;
    ray_ts_pkg::tri_t             pos1_reg;
    logic [2:0][DiffW-1:0]        e1_reg, e1_next, f1_reg, f1_next;

    logic [5:0][ProdW-1:0]        prod2_reg, prod2_next;
    ray_ts_pkg::idx3_t            idx2_reg;
    ray_ts_pkg::tri_t             pos2_reg;
    logic                         dup2_reg, dup2_next;

    logic [2:0][CrossW-1:0]       cross3_reg, cross3_next;
    ray_ts_pkg::idx3_t            idx3_reg;
    ray_ts_pkg::tri_t             pos3_reg;
    logic                         dup3_reg;

    logic [2:0][MagW-1:0]         mag4_reg, mag4_next;
    logic [2:0]                   sgn4_reg, sgn4_next;
    ray_ts_pkg::idx3_t            idx4_reg;
    ray_ts_pkg::tri_t             pos4_reg;
    logic                         dup4_reg;

    logic [2:0][MagW-1:0]         mag5_reg;
    logic [LenW-1:0]              len5_reg, len5_next;
    ray_ts_pkg::axis_t            dropped5_reg, dropped5_next;
    logic                         zero5_reg, zero5_next;
    logic                         valid5_reg, valid5_next;
    logic [2:0]                   sgn5_reg;
    ray_ts_pkg::idx3_t            idx5_reg;
    ray_ts_pkg::tri_t             pos5_reg;

    ray_ts_pkg::m3_t              m6_reg, m6_next;
    logic [2:0][DiffW-1:0]        elen6_reg, elen6_next;
    ray_ts_pkg::axis_t            dropped6_reg;
    logic                         zero6_reg;
    logic                         valid6_reg;
    logic [2:0]                   sgn6_reg;
    ray_ts_pkg::idx3_t            idx6_reg;
    ray_ts_pkg::vec3_t            p06_reg;

    logic [2:0][SqW-1:0]          sq7_reg, sq7_next;
    ray_ts_pkg::m3_t              m7_reg;
    ray_ts_pkg::side_t            side7_reg, side7_next;

    logic [SumW-1:0]              sum8_reg, sum8_next;
    ray_ts_pkg::m3_t              m8_reg;
    ray_ts_pkg::side_t            side8_reg;

    // Stage 1: offset indices and edge vectors.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            idx1_next[i] = {1'b0, in_index[i]} + {1'b0, index_offset};
            e1_next[i] = {in_pos[1][i][PosW-1], in_pos[1][i]}
                       - {in_pos[0][i][PosW-1], in_pos[0][i]};
            f1_next[i] = {in_pos[2][i][PosW-1], in_pos[2][i]}
                       - {in_pos[0][i][PosW-1], in_pos[0][i]};
        end
    end

    // Stage 2: the six partial products and duplicate checks.
    always_comb
    begin
        logic signed [ProdW-1:0] ex [3];
        logic signed [ProdW-1:0] fx [3];
        for (int i = 0; i < 3; i++)
        begin
            ex[i] = ProdW'($signed(e1_reg[i]));
            fx[i] = ProdW'($signed(f1_reg[i]));
        end
        prod2_next[0] = ex[1] * fx[2];
        prod2_next[1] = ex[2] * fx[1];
        prod2_next[2] = ex[2] * fx[0];
        prod2_next[3] = ex[0] * fx[2];
        prod2_next[4] = ex[0] * fx[1];
        prod2_next[5] = ex[1] * fx[0];
        dup2_next = (idx1_reg[0] == idx1_reg[1]) || (idx1_reg[0] == idx1_reg[2])
                 || (idx1_reg[1] == idx1_reg[2])
                 || (pos1_reg[0] == pos1_reg[1]) || (pos1_reg[1] == pos1_reg[2])
                 || (pos1_reg[2] == pos1_reg[0]);
    end

    // Stage 3: cross product components.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            cross3_next[i] = {prod2_reg[2*i][ProdW-1], prod2_reg[2*i]}
                           - {prod2_reg[2*i+1][ProdW-1], prod2_reg[2*i+1]};
        end
    end

    // Stage 4: sign and magnitude.
    always_comb
    begin
        logic [CrossW-1:0] neg;
        for (int i = 0; i < 3; i++)
        begin
            neg = CrossW'(0) - cross3_reg[i];
            sgn4_next[i] = cross3_reg[i][CrossW-1];
            mag4_next[i] = sgn4_next[i] ? neg[MagW-1:0] : cross3_reg[i][MagW-1:0];
        end
    end

    // Stage 5: dominant axis, common bit length and validity.
    always_comb
    begin
        logic [MagW-1:0] any;
        any = mag4_reg[0] | mag4_reg[1] | mag4_reg[2];
        len5_next  = bit_len(any);
        zero5_next = (any == '0);
        valid5_next = !(dup4_reg || zero5_next);
        if ((mag4_reg[0] > mag4_reg[1]) && (mag4_reg[0] > mag4_reg[2]))
        begin
            dropped5_next = ray_ts_pkg::AXIS_X;
        end
        else if (mag4_reg[1] > mag4_reg[2])
        begin
            dropped5_next = ray_ts_pkg::AXIS_Y;
        end
        else
        begin
            dropped5_next = ray_ts_pkg::AXIS_Z;
        end
    end

    // Stage 6: scale the magnitudes by a common shift that puts the largest into [2^30, 2^31), and measure the edges.
    always_comb
    begin
        logic [ShiftW-1:0] sh;
        logic [DiffW-1:0]  dv;
        logic [PosW-1:0]   ka [3];
        logic              use_y;
        for (int i = 0; i < 3; i++)
        begin
            sh = {{MW{1'b0}}, mag5_reg[i]};
            sh = sh << MW;
            sh = sh >> len5_reg;
            m6_next[i] = sh[MW-1:0];
        end
        use_y = (dropped5_reg == ray_ts_pkg::AXIS_X);
        for (int v = 0; v < 3; v++)
        begin
            ka[v] = use_y ? pos5_reg[v][1] : pos5_reg[v][0];
        end
        for (int i = 0; i < 3; i++)
        begin
            dv = {ka[(i + 1) % 3][PosW-1], ka[(i + 1) % 3]} - {ka[i][PosW-1], ka[i]};
            elen6_next[i] = dv[DiffW-1] ? (DiffW'(0) - dv) : dv;
        end
    end

    // Stage 7: squares and vertex rotation.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq7_next[i] = SqW'(m6_reg[i]) * SqW'(m6_reg[i]);
        end
        side7_next.dropped = dropped6_reg;
        side7_next.valid   = valid6_reg;
        side7_next.zero    = zero6_reg;
        side7_next.sgn     = sgn6_reg;
        side7_next.p0      = p06_reg;
        if ((elen6_reg[0] >= elen6_reg[1]) && (elen6_reg[0] >= elen6_reg[2]))
        begin
            side7_next.idx = idx6_reg;
        end
        else if (elen6_reg[1] >= elen6_reg[2])
        begin
            side7_next.idx = {idx6_reg[0], idx6_reg[2], idx6_reg[1]};
        end
        else
        begin
            side7_next.idx = {idx6_reg[1], idx6_reg[0], idx6_reg[2]};
        end
    end

    // Stage 8: sum of squares.
    assign sum8_next = SumW'(sq7_reg[0]) + SumW'(sq7_reg[1]) + SumW'(sq7_reg[2]);

    // Valid bits move with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[Depth-2:0], in_valid};
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            idx1_reg     <= idx1_next;
            pos1_reg     <= in_pos;
            e1_reg       <= e1_next;
            f1_reg       <= f1_next;

            prod2_reg    <= prod2_next;
            idx2_reg     <= idx1_reg;
            pos2_reg     <= pos1_reg;
            dup2_reg     <= dup2_next;

            cross3_reg   <= cross3_next;
            idx3_reg     <= idx2_reg;
            pos3_reg     <= pos2_reg;
            dup3_reg     <= dup2_reg;

            mag4_reg     <= mag4_next;
            sgn4_reg     <= sgn4_next;
            idx4_reg     <= idx3_reg;
            pos4_reg     <= pos3_reg;
            dup4_reg     <= dup3_reg;

            mag5_reg     <= mag4_reg;
            len5_reg     <= len5_next;
            dropped5_reg <= dropped5_next;
            zero5_reg    <= zero5_next;
            valid5_reg   <= valid5_next;
            sgn5_reg     <= sgn4_reg;
            idx5_reg     <= idx4_reg;
            pos5_reg     <= pos4_reg;

            m6_reg       <= m6_next;
            elen6_reg    <= elen6_next;
            dropped6_reg <= dropped5_reg;
            zero6_reg    <= zero5_reg;
            valid6_reg   <= valid5_reg;
            sgn6_reg     <= sgn5_reg;
            idx6_reg     <= idx5_reg;
            p06_reg      <= pos5_reg[0];

            sq7_reg      <= sq7_next;
            m7_reg       <= m6_reg;
            side7_reg    <= side7_next;

            sum8_reg     <= sum8_next;
            m8_reg       <= m7_reg;
            side8_reg    <= side7_reg;
        end
    end

    assign out_valid = vld_reg[Depth-1];
    assign out_sum   = sum8_reg;
    assign out_m     = m8_reg;
    assign out_side  = side8_reg;

endmodule

// ===== rtl/ray_ts_isqrt.sv =====
// Integer square root, one result bit per register stage.
module ray_ts_isqrt (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [ray_ts_pkg::SUM_W-1:0]    in_sum,
    input  ray_ts_pkg::m3_t                 in_m,
    input  ray_ts_pkg::side_t               in_side,
    output logic                            out_valid,
    output logic [ray_ts_pkg::ROOT_W-1:0]   out_root,
    output ray_ts_pkg::m3_t                 out_m,
    output ray_ts_pkg::side_t               out_side
);
    localparam int Steps = ray_ts_pkg::ROOT_STEPS;
    localparam int SumW  = ray_ts_pkg::SUM_W;
    localparam int RootW = ray_ts_pkg::ROOT_W;

    logic [Steps-1:0]   vld_reg;
    logic [SumW-1:0]    rem_reg [Steps];
    logic [SumW-1:0]    rem_next [Steps];
    logic [SumW-1:0]    res_reg [Steps];
    logic [SumW-1:0]    res_next [Steps];
    ray_ts_pkg::m3_t    m_reg [Steps];
    ray_ts_pkg::side_t  side_reg [Steps];
    logic [SumW-1:0]    rem_cur [Steps];
    logic [SumW-1:0]    res_cur [Steps];

    // Each stage tries one bit of the root against the running remainder.
    always_comb
    begin
        logic [SumW:0]   trial;
        logic [SumW-1:0] bitv;
        rem_cur[0] = in_sum;
        res_cur[0] = '0;
        for (int k = 1; k < Steps; k++)
        begin
            rem_cur[k] = rem_reg[k-1];
            res_cur[k] = res_reg[k-1];
        end
        for (int k = 0; k < Steps; k++)
        begin
            bitv  = SumW'(1) << (2 * (Steps - 1 - k));
            trial = {1'b0, res_cur[k]} + {1'b0, bitv};
            if ({1'b0, rem_cur[k]} >= trial)
            begin
                rem_next[k] = rem_cur[k] - trial[SumW-1:0];
                res_next[k] = (res_cur[k] >> 1) + bitv;
            end
            else
            begin
                rem_next[k] = rem_cur[k];
                res_next[k] = res_cur[k] >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[Steps-2:0], in_valid};
        end
    end

    // Remainder, partial root and the carried payload.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < Steps; k++)
            begin
                rem_reg[k] <= rem_next[k];
                res_reg[k] <= res_next[k];
            end
            m_reg[0]    <= in_m;
            side_reg[0] <= in_side;
            for (int k = 1; k < Steps; k++)
            begin
                m_reg[k]    <= m_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[Steps-1];
    assign out_root  = res_reg[Steps-1][RootW-1:0];
    assign out_m     = m_reg[Steps-1];
    assign out_side  = side_reg[Steps-1];

endmodule

// ===== rtl/ray_ts_div.sv =====
// Three-lane restoring divider: round(m * 2^30 / len), one quotient bit
// per register stage after a stage that forms the numerators.
module ray_ts_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [ray_ts_pkg::ROOT_W-1:0]   in_root,
    input  ray_ts_pkg::m3_t                 in_m,
    input  ray_ts_pkg::side_t               in_side,
    output logic                            out_valid,
    output ray_ts_pkg::q3_t                 out_q,
    output ray_ts_pkg::side_t               out_side
);
    localparam int QW     = ray_ts_pkg::Q_W;
    localparam int Stages = QW + 1;
    localparam int NumW   = ray_ts_pkg::NUM_W;
    localparam int RootW  = ray_ts_pkg::ROOT_W;
    localparam int Frac   = ray_ts_pkg::FRAC_SHIFT;

    logic [Stages-1:0]          vld_reg;
    logic [2:0][NumW-1:0]       rem_reg [Stages];
    logic [2:0][NumW-1:0]       rem_next [Stages];
    ray_ts_pkg::q3_t            q_reg [Stages];
    ray_ts_pkg::q3_t            q_next [Stages];
    logic [RootW-1:0]           ln_reg [Stages];
    ray_ts_pkg::side_t          side_reg [Stages];

    always_comb
    begin
        logic [NumW:0] dvs;
        logic          ge;
        // Numerator with half the divisor added for rounding.
        for (int i = 0; i < 3; i++)
        begin
            rem_next[0][i] = (NumW'(in_m[i]) << Frac) + NumW'(in_root >> 1);
        end
        q_next[0] = '0;
        // Quotient bits from the most significant down.
        for (int k = 1; k < Stages; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dvs = (NumW + 1)'(ln_reg[k-1]) << (Stages - 1 - k);
                ge  = ({1'b0, rem_reg[k-1][i]} >= dvs);
                rem_next[k][i] = ge ? (rem_reg[k-1][i] - dvs[NumW-1:0])
                                    : rem_reg[k-1][i];
                q_next[k][i] = {q_reg[k-1][i][QW-2:0], ge};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[Stages-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < Stages; k++)
            begin
                rem_reg[k] <= rem_next[k];
                q_reg[k]   <= q_next[k];
            end
            ln_reg[0]   <= in_root;
            side_reg[0] <= in_side;
            for (int k = 1; k < Stages; k++)
            begin
                ln_reg[k]   <= ln_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[Stages-1];
    assign out_q     = q_reg[Stages-1];
    assign out_side  = side_reg[Stages-1];

endmodule

// ===== rtl/ray_ts_dist.sv =====
// Signed normal and plane distance: sign, products, sum, round and clamp.
// The last stage is the output register of the block.
module ray_ts_dist (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  ray_ts_pkg::q3_t                 in_q,
    input  ray_ts_pkg::side_t               in_side,
    output logic                            out_valid,
    output ray_ts_pkg::vec3_t               out_normal,
    output logic [ray_ts_pkg::DIST_W-1:0]   out_dist,
    output ray_ts_pkg::side_t               out_side
);
    localparam int Depth = 4;
    localparam int PosW  = ray_ts_pkg::POS_W;
    localparam int SumW  = ray_ts_pkg::SUM_W;
    localparam int DistW = ray_ts_pkg::DIST_W;
    localparam int Frac  = ray_ts_pkg::FRAC_SHIFT;
    localparam int MagW  = SumW - Frac;
    localparam logic [SumW-1:0]  PosLimit = SumW'((64'd1 << (DistW - 1)) - 64'd1);
    localparam logic [SumW-1:0]  NegLimit = SumW'(64'd1 << (DistW - 1));
    localparam logic [SumW-1:0]  Half     = SumW'(64'd1 << (Frac - 1));

    logic [Depth-1:0]           vld_reg;
    ray_ts_pkg::vec3_t          n1_reg, n1_next, n2_reg, n3_reg, n4_reg;
    ray_ts_pkg::side_t          side1_reg, side2_reg, side3_reg, side4_reg;
    logic [2:0][SumW-1:0]       prod2_reg, prod2_next;
    logic [SumW-1:0]            s3_reg, s3_next;
    logic [DistW-1:0]           d4_reg, d4_next;

    // Stage 1: apply the component signs; a zero cross product gives zero.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (in_side.zero)
            begin
                n1_next[i] = '0;
            end
            else if (in_side.sgn[i])
            begin
                n1_next[i] = PosW'(0) - PosW'(in_q[i]);
            end
            else
            begin
                n1_next[i] = PosW'(in_q[i]);
            end
        end
    end

    // Stage 2: vertex times normal, per axis.
    always_comb
    begin
        logic signed [SumW-1:0] pa;
        logic signed [SumW-1:0] na;
        for (int i = 0; i < 3; i++)
        begin
            pa = SumW'($signed(side1_reg.p0[i]));
            na = SumW'($signed(n1_reg[i]));
            prod2_next[i] = pa * na;
        end
    end

    // Stage 3: dot product.
    assign s3_next = prod2_reg[0] + prod2_reg[1] + prod2_reg[2];

    // Stage 4: round half away from zero to 16 fraction bits and clamp.
    always_comb
    begin
        logic             neg;
        logic [SumW-1:0]  a;
        logic [SumW-1:0]  rnd;
        logic [MagW-1:0]  smag;
        logic [DistW-1:0] mag;
        neg  = s3_reg[SumW-1];
        a    = neg ? (SumW'(0) - s3_reg) : s3_reg;
        rnd  = a + Half;
        smag = rnd[SumW-1:Frac];
        if (neg && (SumW'(smag) > NegLimit))
        begin
            mag = NegLimit[DistW-1:0];
        end
        else if (!neg && (SumW'(smag) > PosLimit))
        begin
            mag = PosLimit[DistW-1:0];
        end
        else
        begin
            mag = DistW'(smag);
        end
        d4_next = neg ? (DistW'(0) - mag) : mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[Depth-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_reg    <= n1_next;
            side1_reg <= in_side;
            prod2_reg <= prod2_next;
            n2_reg    <= n1_reg;
            side2_reg <= side1_reg;
            s3_reg    <= s3_next;
            n3_reg    <= n2_reg;
            side3_reg <= side2_reg;
            d4_reg    <= d4_next;
            n4_reg    <= n3_reg;
            side4_reg <= side3_reg;
        end
    end

    assign out_valid  = vld_reg[Depth-1];
    assign out_normal = n4_reg;
    assign out_dist   = d4_reg;
    assign out_side   = side4_reg;

endmodule

// ===== rtl/ray_triangle_setup_unit.sv =====
// Triangle setup for ray tracing.
// Triangles arrive as beats on the s_axis channel: three vertex indices and
// three Q16.16 positions. Each beat yields one setup record on m_axis: the
// Q2.30 unit normal, the Q32.16 plane distance, the dropped axis, the three
// offset indices rotated so the longest projected edge comes first, and the
// material number; m_axis_tuser carries the validity flag.
// The cfg channel writes the index offset and the material number and is
// always ready; the user must write it only while no triangle is in flight.
// The block itself does not enforce this. An accepted beat passes through
// cross product and normalisation, the bit-per-stage square root, the
// bit-per-stage divider and distance arithmetic on its way to m_axis.
// Throughput is one triangle per cycle; every stage takes a new beat each
// cycle while the output advances.
// Reset clears the pipeline valid bits and both configuration registers.
// When the receiver holds m_axis_tready low with a result waiting, the whole
// pipeline holds and s_axis_tready drops; nothing is lost or repeated.
module ray_triangle_setup_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [ray_ts_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ray_ts_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // index_a, index_b, index_c, ax, ay, az, bx, by_coord, bz, cx, cy, cz
    input  logic [ray_ts_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // normal_x, normal_y, normal_z, plane_distance, dropped_axis,
    // vertex_first, vertex_second, vertex_third, material
    output logic [ray_ts_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // is_valid
    output logic                                   m_axis_tuser
);
    localparam int IdxInW  = ray_ts_pkg::IDX_IN_W;
    localparam int PosW    = ray_ts_pkg::POS_W;
    localparam int MatW    = ray_ts_pkg::MAT_W;
    localparam int PosBase = 3 * IdxInW;
    localparam int UsedW   = 6 * PosW + ray_ts_pkg::DIST_W + 2 + MatW;
    localparam int PadW    = ray_ts_pkg::OUT_DATA_W - UsedW;

    logic [IdxInW-1:0]              offset_reg;
    logic [MatW-1:0]                material_reg;
    logic                           adv;

    ray_ts_pkg::idx_in3_t           in_index;
    ray_ts_pkg::tri_t               in_pos;

    logic                           fr_valid, sq_valid, dv_valid;
    logic [ray_ts_pkg::SUM_W-1:0]   fr_sum;
    ray_ts_pkg::m3_t                fr_m, sq_m;
    ray_ts_pkg::side_t              fr_side, sq_side, dv_side, out_side;
    logic [ray_ts_pkg::ROOT_W-1:0]  sq_root;
    ray_ts_pkg::q3_t                dv_q;
    ray_ts_pkg::vec3_t              out_normal;
    logic [ray_ts_pkg::DIST_W-1:0]  out_dist;

    // Configuration writes.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg   <= '0;
            material_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                ray_ts_pkg::CFG_INDEX_OFFSET: offset_reg   <= cfg_data[IdxInW-1:0];
                ray_ts_pkg::CFG_MATERIAL:     material_reg <= cfg_data[MatW-1:0];
                default:                      ;
            endcase
        end
    end

    // The whole pipeline advances unless a finished beat is held at the output.
    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    // Unpack the input beat.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            in_index[i] = s_axis_tdata[IdxInW * i +: IdxInW];
        end
        for (int v = 0; v < 3; v++)
        begin
            for (int a = 0; a < 3; a++)
            begin
                in_pos[v][a] = s_axis_tdata[PosBase + PosW * (3 * v + a) +: PosW];
            end
        end
    end

    ray_ts_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (adv),
        .in_valid     (s_axis_tvalid),
        .index_offset (offset_reg),
        .in_index     (in_index),
        .in_pos       (in_pos),
        .out_valid    (fr_valid),
        .out_sum      (fr_sum),
        .out_m        (fr_m),
        .out_side     (fr_side)
    );

    ray_ts_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (fr_valid),
        .in_sum    (fr_sum),
        .in_m      (fr_m),
        .in_side   (fr_side),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_m     (sq_m),
        .out_side  (sq_side)
    );

    ray_ts_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (sq_valid),
        .in_root   (sq_root),
        .in_m      (sq_m),
        .in_side   (sq_side),
        .out_valid (dv_valid),
        .out_q     (dv_q),
        .out_side  (dv_side)
    );

    ray_ts_dist u_dist (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .in_valid   (dv_valid),
        .in_q       (dv_q),
        .in_side    (dv_side),
        .out_valid  (m_axis_tvalid),
        .out_normal (out_normal),
        .out_dist   (out_dist),
        .out_side   (out_side)
    );

    // Pack the result beat.
    assign m_axis_tdata = {
        {PadW{1'b0}},
        material_reg,
        out_side.idx[2],
        out_side.idx[1],
        out_side.idx[0],
        out_side.dropped,
        out_dist,
        out_normal[2],
        out_normal[1],
        out_normal[0]
    };
    assign m_axis_tuser = out_side.valid;

endmodule
